### sv/idct_pkg.sv
package idct_pkg;

    // Default coefficient width and fixed field widths.
    localparam int CoefWidthDef = 16;
    localparam int SampleWidth  = 16;
    localparam int PrecWidth    = 5;
    localparam int AccWidth     = 32;

    // Multiplier constants of the 8-point transform, 13 fraction bits.
    localparam logic [AccWidth-1:0] K_0_298 = 32'd2446;
    localparam logic [AccWidth-1:0] K_0_390 = 32'd3196;
    localparam logic [AccWidth-1:0] K_0_541 = 32'd4433;
    localparam logic [AccWidth-1:0] K_0_765 = 32'd6270;
    localparam logic [AccWidth-1:0] K_0_899 = 32'd7373;
    localparam logic [AccWidth-1:0] K_1_175 = 32'd9633;
    localparam logic [AccWidth-1:0] K_1_501 = 32'd12299;
    localparam logic [AccWidth-1:0] K_1_847 = 32'd15137;
    localparam logic [AccWidth-1:0] K_1_961 = 32'd16069;
    localparam logic [AccWidth-1:0] K_2_053 = 32'd16819;
    localparam logic [AccWidth-1:0] K_2_562 = 32'd20995;
    localparam logic [AccWidth-1:0] K_3_072 = 32'd25172;

    typedef logic [AccWidth-1:0] t_word;

    // Control handed from the sequencer to the 8-point unit.
    typedef struct packed {
        logic       start;
        logic       second;
    } t_pt_ctrl;

endpackage

### sv/idct_8x8_islow.sv
// 8x8 integer inverse DCT. Coefficients enter one per start pulse in row-major
// order while busy is low. After the 64th, busy rises and the block runs
// 8 column and 8 row transforms on one shared multiplier-adder. Each transform
// gathers its eight operands, runs its 30 microsteps in the arithmetic unit
// (started by a registered strobe and seen to finish on its done flag) and
// then stores its eight results. The 64 samples then leave one at a time on
// o_sample_valid, with o_block_last on the last, so busy stays high from the
// final coefficient of a block until the last sample is sent. The
// receiver cannot stall: every strobed word must be taken in that cycle.
// i_sample_precision_we writes the precision, which is clamped to 2..16 and
// sampled when the final coefficient arrives.
module idct_8x8_islow #(
    parameter int COEF_WIDTH = idct_pkg::CoefWidthDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COEF_WIDTH-1:0] i_coefficient,
    input  logic                  i_sample_precision_we,
    input  logic [4:0]            i_sample_precision,
    output logic                  o_sample_valid,
    output logic [15:0]           o_sample,
    output logic                  o_block_last
);
    import idct_pkg::*;

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_STOR = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [5:0] r_fill;
    logic [3:0] r_pass;     // bit 3 = row pass, [2:0] = line index
    logic [3:0] r_sub;      // gather / store counter
    logic [5:0] r_out;
    logic [4:0] r_prec;
    logic [4:0] r_prec_used;

    // Coefficient and intermediate memories.
    t_word r_cmem [64];
    t_word r_pmem [64];
    t_word r_rd_c, r_rd_p, r_rd_o;
    t_word r_x [8];
    logic [5:0] m_raddr;

    t_pt_ctrl m_ctrl;
    logic     m_done;
    t_word    m_y [8];

    assign busy = (r_state != S_FILL);

    // Read address for the operand gather: column pass walks a column, row pass a row.
    always_comb begin
        if (r_pass[3]) m_raddr = {r_pass[2:0], r_sub[2:0]};
        else           m_raddr = {r_sub[2:0], r_pass[2:0]};
    end

    // The coefficient memory takes input words while filling and row results
    // afterwards; the pass memory holds column results.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmem[r_fill] <= t_word'($signed(i_coefficient));
        end else if (r_state == S_STOR && r_pass[3]) begin
            r_cmem[{r_pass[2:0], r_sub[2:0]}] <= m_y[r_sub[2:0]];
        end
        if (r_state == S_STOR && !r_pass[3]) begin
            r_pmem[{r_sub[2:0], r_pass[2:0]}] <= m_y[r_sub[2:0]];
        end
        r_rd_c <= r_cmem[m_raddr];
        r_rd_p <= r_pmem[m_raddr];
        r_rd_o <= r_cmem[r_out];
    end

    // Gather: data for index sub-1 arrives in the cycle after its address.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && r_sub != 4'd0) begin
            r_x[3'(r_sub - 4'd1)] <= r_pass[3] ? r_rd_p : r_rd_c;
        end
    end

    assign m_ctrl.start  = (r_state == S_LOAD) && (r_sub == 4'd8);
    assign m_ctrl.second = r_pass[3];

    // Actually start after final operand is written: the start is registered.
    t_pt_ctrl r_ctrl;
    always_ff @(posedge i_clk) r_ctrl <= m_ctrl;

    idct_pt8 u_pt8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl),
        .i_x     (r_x),
        .o_done  (m_done),
        .o_y     (m_y)
    );

    // Output sample: level shift and clamp of a row result.
    t_word m_v, m_ceil, m_shift;
    logic [4:0] m_pc;
    always_comb begin
        m_pc = r_prec_used;
        if (m_pc < 5'd2)  m_pc = 5'd2;
        if (m_pc > 5'd16) m_pc = 5'd16;
        m_shift = t_word'(1) << (m_pc - 5'd1);
        m_ceil  = (t_word'(1) << m_pc) - 1'b1;
        m_v     = r_rd_o + m_shift;
        if (!($signed(m_v) < $signed(m_ceil))) m_v = m_ceil;
        if (m_v[AccWidth-1]) m_v = '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: if (start && r_fill == 6'd63) n_state = S_LOAD;
            S_LOAD: if (r_sub == 4'd8) n_state = S_RUN;
            S_RUN:  if (m_done) n_state = S_STOR;
            S_STOR: if (r_sub == 4'd7) begin
                        if (r_pass == 4'd15) n_state = S_OUT;
                        else                 n_state = S_LOAD;
                    end
            S_OUT:  if (r_out == 6'd63 && r_sub == 4'd1) n_state = S_FILL;
            default: n_state = S_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_FILL;
            r_fill         <= '0;
            r_pass         <= '0;
            r_sub          <= '0;
            r_out          <= '0;
            r_prec         <= 5'd8;
            r_prec_used    <= 5'd8;
            o_sample_valid <= 1'b0;
            o_block_last   <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_sample_valid <= (r_state == S_OUT) && (r_sub == 4'd1);
            o_block_last   <= (r_state == S_OUT) && (r_sub == 4'd1) && (r_out == 6'd63);
            if (i_sample_precision_we) r_prec <= i_sample_precision;
            unique case (r_state)
                S_FILL: begin
                    if (start) begin
                        r_fill <= r_fill + 1'b1;
                        if (r_fill == 6'd63) begin
                            r_prec_used <= i_sample_precision_we ? i_sample_precision : r_prec;
                            r_pass      <= '0;
                            r_sub       <= '0;
                        end
                    end
                end
                S_LOAD: r_sub <= (r_sub == 4'd8) ? 4'd0 : r_sub + 1'b1;
                S_RUN:  r_sub <= '0;
                S_STOR: begin
                    r_sub <= (r_sub == 4'd7) ? 4'd0 : r_sub + 1'b1;
                    if (r_sub == 4'd7) begin
                        r_pass <= r_pass + 1'b1;
                        r_out  <= '0;
                    end
                end
                S_OUT: begin
                    if (r_sub == 4'd1) begin
                        o_sample <= m_v[15:0];
                        r_out    <= r_out + 1'b1;
                        r_sub    <= '0;
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    property p_fill_idle;
        @(posedge i_clk) disable iff (!i_rst_n) busy |=> $stable(r_fill);
    endproperty
    a_fill_idle: assert property (p_fill_idle) else $error("fill moved while busy");

    property p_last_valid;
        @(posedge i_clk) disable iff (!i_rst_n) o_block_last |-> o_sample_valid;
    endproperty
    a_last_valid: assert property (p_last_valid) else $error("last without valid");

    property p_out_only;
        @(posedge i_clk) disable iff (!i_rst_n) o_sample_valid |-> $past(r_state) == S_OUT;
    endproperty
    a_out_only: assert property (p_out_only) else $error("sample outside output");

endmodule

### sv/idct_pt8.sv
// Eight-point inverse transform over one shared 32x32 multiplier and its accumulate adder.
// Operands are loaded into x, then a microprogram of multiply/accumulate steps
// runs one step per cycle; the result is descaled by 11 or 18 bits.
module idct_pt8 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idct_pkg::t_pt_ctrl   i_ctrl,
    input  idct_pkg::t_word      i_x [8],
    output logic                 o_done,
    output idct_pkg::t_word      o_y [8]
);
    import idct_pkg::*;

    localparam int NSteps = 36;
    localparam int StepW  = 6;

    logic [StepW-1:0] r_step, n_step;
    logic             r_busy, n_busy;
    logic             r_second;
    t_word            r_x [8];
    t_word            r_t [16];
    t_word            r_y [8];
    logic             r_done;

    // Operand selection for the current microstep: p = a*b, then t[d] = p + c, or y[yi] = descaled p + c.
    t_word  m_a, m_b, m_c, m_p, m_s;
    logic [3:0] m_d;
    logic       m_wr;
    logic [2:0] m_yi;

    // temp map: 0 e1 1 e2 2 e3 3 e0 4 ex 5 t10 6 t13 7 t11 8 t12
    //           9 z5 10 z1 11 z2 12 z3 13 z4 14 oacc 15 scratch
    always_comb begin
        m_a = '0; m_b = '0; m_c = '0; m_d = 4'd15; m_wr = 1'b0; m_yi = 3'd0;
        case (r_step)
            6'd0:  begin m_a = r_x[2] + r_x[6]; m_b = K_0_541; m_d = 4'd0; end
            6'd1:  begin m_a = r_x[6]; m_b = 32'd0 - K_1_847; m_c = r_t[0]; m_d = 4'd1; end
            6'd2:  begin m_a = r_x[2]; m_b = K_0_765; m_c = r_t[0]; m_d = 4'd2; end
            6'd3:  begin m_a = r_x[0] + r_x[4]; m_b = 32'd8192; m_d = 4'd3; end
            6'd4:  begin m_a = r_x[0] - r_x[4]; m_b = 32'd8192; m_d = 4'd4; end
            6'd5:  begin m_a = r_t[2]; m_b = 32'd1; m_c = r_t[3]; m_d = 4'd5; end
            6'd6:  begin m_a = r_t[2]; m_b = 32'hFFFF_FFFF; m_c = r_t[3]; m_d = 4'd6; end
            6'd7:  begin m_a = r_t[1]; m_b = 32'd1; m_c = r_t[4]; m_d = 4'd7; end
            6'd8:  begin m_a = r_t[1]; m_b = 32'hFFFF_FFFF; m_c = r_t[4]; m_d = 4'd8; end
            6'd9:  begin m_a = r_x[7] + r_x[3] + r_x[5] + r_x[1]; m_b = K_1_175;
                         m_d = 4'd9; end
            6'd10: begin m_a = r_x[7] + r_x[1]; m_b = 32'd0 - K_0_899; m_d = 4'd10; end
            6'd11: begin m_a = r_x[5] + r_x[3]; m_b = 32'd0 - K_2_562; m_d = 4'd11; end
            6'd12: begin m_a = r_x[7] + r_x[3]; m_b = 32'd0 - K_1_961; m_c = r_t[9];
                         m_d = 4'd12; end
            6'd13: begin m_a = r_x[5] + r_x[1]; m_b = 32'd0 - K_0_390; m_c = r_t[9];
                         m_d = 4'd13; end
            // o0 = x7*k + z1 + z3
            6'd14: begin m_a = r_x[7]; m_b = K_0_298; m_c = r_t[10]; m_d = 4'd14; end
            6'd15: begin m_a = r_t[12]; m_b = 32'd1; m_c = r_t[14]; m_d = 4'd14; end
            6'd16: begin m_a = r_t[14]; m_b = 32'd1; m_c = r_t[6]; m_wr = 1'b1; m_yi = 3'd3; end
            6'd17: begin m_a = r_t[14]; m_b = 32'hFFFF_FFFF; m_c = r_t[6]; m_wr = 1'b1;
                         m_yi = 3'd4; end
            // o1 = x5*k + z2 + z4
            6'd18: begin m_a = r_x[5]; m_b = K_2_053; m_c = r_t[11]; m_d = 4'd14; end
            6'd19: begin m_a = r_t[13]; m_b = 32'd1; m_c = r_t[14]; m_d = 4'd14; end
            6'd20: begin m_a = r_t[14]; m_b = 32'd1; m_c = r_t[8]; m_wr = 1'b1; m_yi = 3'd2; end
            6'd21: begin m_a = r_t[14]; m_b = 32'hFFFF_FFFF; m_c = r_t[8]; m_wr = 1'b1;
                         m_yi = 3'd5; end
            // o2 = x3*k + z2 + z3
            6'd22: begin m_a = r_x[3]; m_b = K_3_072; m_c = r_t[11]; m_d = 4'd14; end
            6'd23: begin m_a = r_t[12]; m_b = 32'd1; m_c = r_t[14]; m_d = 4'd14; end
            6'd24: begin m_a = r_t[14]; m_b = 32'd1; m_c = r_t[7]; m_wr = 1'b1; m_yi = 3'd1; end
            6'd25: begin m_a = r_t[14]; m_b = 32'hFFFF_FFFF; m_c = r_t[7]; m_wr = 1'b1;
                         m_yi = 3'd6; end
            // o3 = x1*k + z1 + z4
            6'd26: begin m_a = r_x[1]; m_b = K_1_501; m_c = r_t[10]; m_d = 4'd14; end
            6'd27: begin m_a = r_t[13]; m_b = 32'd1; m_c = r_t[14]; m_d = 4'd14; end
            6'd28: begin m_a = r_t[14]; m_b = 32'd1; m_c = r_t[5]; m_wr = 1'b1; m_yi = 3'd0; end
            6'd29: begin m_a = r_t[14]; m_b = 32'hFFFF_FFFF; m_c = r_t[5]; m_wr = 1'b1;
                         m_yi = 3'd7; end
            default: ;
        endcase
    end

    assign m_p = m_a * m_b;
    assign m_s = m_p + m_c;

    // Rounded arithmetic descale of an output sum.
    t_word m_rnd, m_dsc;
    assign m_rnd = m_s + (r_second ? 32'h0002_0000 : 32'h0000_0400);
    assign m_dsc = r_second ? t_word'($signed(m_rnd) >>> 18) : t_word'($signed(m_rnd) >>> 11);

    // Sequencer of microsteps.
    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (i_ctrl.start && !r_busy) begin
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_step == StepW'(NSteps - 7)) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            r_done <= r_busy && (r_step == StepW'(NSteps - 7));
        end
    end

    // Operand load and temporaries.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start && !r_busy) begin
            r_x      <= i_x;
            r_second <= i_ctrl.second;
        end
        if (r_busy) begin
            if (m_wr) begin
                r_y[m_yi] <= m_dsc;
            end else begin
                r_t[m_d] <= m_s;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without run");

    property p_step_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_step <= StepW'(NSteps - 7));
    endproperty
    a_step_range: assert property (p_step_range) else $error("step out of range");

    property p_done_ends;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> !r_busy;
    endproperty
    a_done_ends: assert property (p_done_ends) else $error("done while busy");

endmodule
